@@ sv/lmmpc_pkg.sv @@
// Shared types and constants for the partition-counting median block.
// No dependencies; used by the top level and the search engine.
`default_nettype none
package lmmpc_pkg;

  localparam int DEPTH_DEF        = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS        = 16;
  localparam int JUMP_LIMIT       = 64;
  localparam int STEP_CAP_LOG     = 50;

  localparam int MAX_DIFF_W = 11;
  localparam int SCALE_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FACTOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHRINK_FACTOR = 2'd2;

  localparam logic [MAX_DIFF_W-1:0] MAX_DIFF_RST      = 11'd5;
  localparam logic [SCALE_W-1:0]    STEP_FACTOR_RST   = 16'd13107;
  localparam logic [SCALE_W-1:0]    SHRINK_FACTOR_RST = 16'd32768;

  typedef struct packed {
    logic [MAX_DIFF_W-1:0] max_diff;
    logic [SCALE_W-1:0]    step_factor;
    logic [SCALE_W-1:0]    shrink_factor;
  } cfg_t;

  typedef enum logic {
    T_LOAD,
    T_BUSY
  } top_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_DIVFIN,
    S_LOOP,
    S_PASS,
    S_DECIDE,
    S_SHRINK,
    S_MULA,
    S_MULB,
    S_APPLY,
    S_DONE
  } search_state_e;

endpackage
`default_nettype wire

@@ sv/low_memory_median_by_partition_counting_top.sv @@
// Top level of the partition-counting median block: stream ports,
// configuration registers, load counter, output register.
// Depends on lmmpc_pkg, lmmpc_mem and lmmpc_search.
//
// Samples arrive on the s_axis channel, one per cycle, into an internal
// store; the request with tlast set starts the search over the stored set.
// Samples beyond DEPTH are dropped (a dropped last still starts the search).
// While the search runs s_axis_tready_o is low. One result (twice the
// median and the sample count) leaves on m_axis.
// A search for n samples runs a sum/min/max sweep, then the bit-serial mean
// divider, then counting passes (a pass may be followed by a scaled jump, and
// by a shrink of the jump scale before it); every pass is a full sweep over
// the single read port of the sample store. Typical sets need a handful of
// passes.
// For 1 or 2 samples the result follows the sweep.
// The result sits in an output register; a new set may load while it waits,
// and a finished search holds until that register is free.
// Reset empties the store count, restores the register defaults and drops
// any pending result. cfg writes are always ready; write only when idle.
`default_nettype none
module low_memory_median_by_partition_counting_top #(
  parameter int DEPTH        = lmmpc_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = lmmpc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    s_axis_tvalid_i,
  output logic                                         s_axis_tready_o,
  // sample
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_axis_tdata_i,
  input  wire logic                                    s_axis_tlast_i,
  output logic                                         m_axis_tvalid_o,
  input  wire logic                                    m_axis_tready_i,
  // median_doubled, sample_count
  output logic [((SAMPLE_WIDTH+1+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata_o,
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [lmmpc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [lmmpc_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int CW  = $clog2(DEPTH+1);
  localparam int AW  = $clog2(DEPTH);
  localparam int RW  = SW + 1;
  localparam int OTW = ((RW + CW + 7) / 8) * 8;

  lmmpc_pkg::top_state_e state_q, state_d;
  lmmpc_pkg::cfg_t       cfg_q;

  logic [CW-1:0] cnt_q, n_q, n_start;
  logic          m_valid_q;
  logic [RW-1:0] out_med_q;
  logic [CW-1:0] out_cnt_q;

  logic          s_acc, room, we, start, ack, done, rd_en;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_data;
  logic [RW-1:0] median;

  assign s_axis_tready_o = state_q == lmmpc_pkg::T_LOAD;
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign room    = cnt_q < CW'(DEPTH);
  assign we      = s_acc && room;
  assign n_start = room ? (cnt_q + CW'(1)) : cnt_q;
  assign start   = s_acc && s_axis_tlast_i;
  assign ack     = (state_q == lmmpc_pkg::T_BUSY) && (!m_valid_q || m_axis_tready_i);
  assign cfg_ready_o = 1'b1;

  lmmpc_mem #(.DEPTH(DEPTH), .SW(SW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i[SW-1:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  lmmpc_search #(.DEPTH(DEPTH), .SW(SW)) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .n_i       (n_start),
    .cfg_i     (cfg_q),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .done_o    (done),
    .ack_i     (ack),
    .median_o  (median)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      lmmpc_pkg::T_LOAD: if (start) state_d = lmmpc_pkg::T_BUSY;
      lmmpc_pkg::T_BUSY: if (done && ack) state_d = lmmpc_pkg::T_LOAD;
      default:           state_d = lmmpc_pkg::T_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= lmmpc_pkg::T_LOAD;
      cnt_q               <= '0;
      m_valid_q           <= 1'b0;
      cfg_q.max_diff      <= lmmpc_pkg::MAX_DIFF_RST;
      cfg_q.step_factor   <= lmmpc_pkg::STEP_FACTOR_RST;
      cfg_q.shrink_factor <= lmmpc_pkg::SHRINK_FACTOR_RST;
    end else begin
      state_q <= state_d;
      if (start) begin
        cnt_q <= '0;
      end else if (we) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (done && ack) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          lmmpc_pkg::REG_MAX_DIFF:
            cfg_q.max_diff <= cfg_data_i[lmmpc_pkg::MAX_DIFF_W-1:0];
          lmmpc_pkg::REG_STEP_FACTOR:   cfg_q.step_factor   <= cfg_data_i;
          lmmpc_pkg::REG_SHRINK_FACTOR: cfg_q.shrink_factor <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) n_q <= n_start;
    if (done && ack) begin
      out_med_q <= median;
      out_cnt_q <= n_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OTW'({out_cnt_q, out_med_q});

endmodule
`default_nettype wire

@@ sv/lmmpc_mem.sv @@
// Sample store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`default_nettype none
module lmmpc_mem #(
  parameter int DEPTH = 1024,
  parameter int SW    = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [SW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [SW-1:0]            rdata_o
);

  logic [SW-1:0] mem_q [DEPTH];
  logic [SW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/lmmpc_search.sv @@
// Median search engine: sum/min/max sweep, mean divider, counting passes
// and the jump datapath. Reads the sample store; uses lmmpc_pkg.
`default_nettype none
module lmmpc_search #(
  parameter int DEPTH = lmmpc_pkg::DEPTH_DEF,
  parameter int SW    = lmmpc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]      n_i,
  input  wire lmmpc_pkg::cfg_t                 cfg_i,
  output logic                                 rd_en_o,
  output logic      [$clog2(DEPTH)-1:0]        rd_addr_o,
  input  wire logic [SW-1:0]                   rd_data_i,
  output logic                                 done_o,
  input  wire logic                            ack_i,
  output logic      [SW:0]                     median_o
);

  localparam int FB   = lmmpc_pkg::FRAC_BITS;
  localparam int CW   = $clog2(DEPTH+1);
  localparam int AW   = $clog2(DEPTH);
  localparam int SUMW = SW + CW;
  localparam int DW   = SUMW + FB;
  localparam int DCW  = $clog2(DW+1);
  localparam int GW   = SW + 1 + FB;
  localparam int RW   = SW + 1;
  localparam int PCAP = lmmpc_pkg::JUMP_LIMIT + DEPTH + 4;
  localparam int PCW  = $clog2(PCAP+1);
  localparam int SCW  = lmmpc_pkg::SCALE_W;
  localparam int GPW  = SW + 1;
  localparam int AMW  = CW + SCW;
  localparam int PW   = AMW + GPW;
  localparam int STW  = lmmpc_pkg::STEP_CAP_LOG + 1;
  localparam int NW   = ((GW > STW) ? GW : STW) + 2;
  localparam int XW   = (((PW - FB) > STW) ? (PW - FB) : STW) + 1;
  localparam int CMPW = (CW > lmmpc_pkg::MAX_DIFF_W) ? CW : lmmpc_pkg::MAX_DIFF_W;

  lmmpc_pkg::search_state_e state_q, state_d;

  logic [CW-1:0]          n_q, idx_q;
  logic                   rv_q;
  logic signed [SUMW-1:0] sum_q;
  logic signed [SW-1:0]   mn_q, mx_q, nb_q, na_q;
  logic [DW-1:0]          div_q;
  logic [CW:0]            rem_q;
  logic [DCW-1:0]         dcnt_q;
  logic                   dneg_q;
  logic signed [GW-1:0]   guess_q, pguess_q, base_q;
  logic signed [CW:0]     pimb_q;
  logic                   pinf_q, bv_q, av_q, neg_q;
  logic [SCW-1:0]         js_q;
  logic [GPW-1:0]         gap_q;
  logic [CW-1:0]          lo_q, hi_q, mag_q;
  logic [PCW-1:0]         pass_q;
  logic [AMW-1:0]         a_q;
  logic [PW-1:0]          prod_q;
  logic [RW-1:0]          med_q;

  // sweep
  logic sweep_end;
  logic signed [SW-1:0] s;
  logic signed [GW-1:0] v;
  assign s         = rd_data_i;
  assign v         = {s[SW-1], s, {FB{1'b0}}};
  assign rd_en_o   = ((state_q == lmmpc_pkg::S_SUM) || (state_q == lmmpc_pkg::S_PASS))
                     && (idx_q < n_q);
  assign rd_addr_o = idx_q[AW-1:0];
  assign sweep_end = (idx_q == n_q) && !rv_q;

  // divider step
  logic [CW:0] rem_t;
  logic        dge;
  assign rem_t = {rem_q[CW-1:0], div_q[DW-1]};
  assign dge   = rem_t >= {1'b0, n_q};

  logic [SUMW-1:0]    sum_abs;
  logic signed [DW:0] qpos, qfin;
  assign sum_abs = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
  assign qpos    = $signed({1'b0, div_q}) + $signed({{DW{1'b0}}, |rem_q});
  assign qfin    = dneg_q ? -qpos : $signed({1'b0, div_q});

  // decision
  logic [CW:0]        same_w;
  logic [CW-1:0]      same, imb, d, pmag;
  logic signed [CW:0] pabs;
  logic signed [SW:0] g, bl, ab, nearv;
  logic [RW-1:0]      blab, g2, n2, half, answer;
  logic               even, gt, eqc, resolved, take_jump, shrink_sel;
  logic signed [SW+1:0] gapw;

  assign same_w = {1'b0, lo_q} + {1'b0, hi_q} - {1'b0, n_q};
  assign same   = same_w[CW-1:0];
  assign g      = guess_q[GW-1:FB];
  assign bl     = bv_q ? {nb_q[SW-1], nb_q} : g;
  assign ab     = av_q ? {na_q[SW-1], na_q} : g;
  assign even   = ~n_q[0];
  assign gt     = lo_q > hi_q;
  assign eqc    = lo_q == hi_q;
  assign imb    = gt ? (lo_q - hi_q) : (hi_q - lo_q);
  assign nearv  = gt ? bl : ab;
  assign resolved = imb <= same;
  assign d      = imb - same;
  assign blab   = RW'(bl + ab);
  assign g2     = {g[SW-1:0], 1'b0};
  assign n2     = {nearv[SW-1:0], 1'b0};
  assign half   = gt ? RW'(bl + g) : RW'(g + ab);
  assign pabs   = pimb_q[CW] ? -pimb_q : pimb_q;
  assign pmag   = pabs[CW-1:0];
  assign take_jump  = (CMPW'(d) > CMPW'(cfg_i.max_diff))
                      && (pass_q < PCW'(lmmpc_pkg::JUMP_LIMIT));
  assign shrink_sel = !pinf_q && (pmag < d);
  assign gapw   = (SW+2)'(ab) - (SW+2)'(bl);

  always_comb begin
    if (eqc) begin
      answer = (same == '0) ? blab : g2;
    end else if (same != '0) begin
      answer = (even && (same == CW'(1))) ? half : g2;
    end else begin
      answer = even ? blab : n2;
    end
  end

  // jump apply
  logic [XW-1:0]        xs, cap, st_x;
  logic signed [NW-1:0] st_e, base_e, lo_e, hi_e, newg, clg;
  assign xs     = XW'(prod_q[PW-1:FB]);
  assign cap    = XW'(1) << lmmpc_pkg::STEP_CAP_LOG;
  assign st_x   = (xs > cap) ? cap : xs;
  assign st_e   = $signed(NW'(st_x[STW-1:0]));
  assign base_e = NW'(base_q);
  assign lo_e   = NW'($signed({mn_q[SW-1], mn_q, {FB{1'b0}}}));
  assign hi_e   = NW'($signed({mx_q[SW-1], mx_q, {FB{1'b0}}}));
  assign newg   = neg_q ? (base_e - st_e) : (base_e + st_e);
  assign clg    = (newg < lo_e) ? lo_e : ((newg > hi_e) ? hi_e : newg);

  logic [2*SCW-1:0] js_prod;
  assign js_prod = js_q * cfg_i.shrink_factor;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lmmpc_pkg::S_IDLE:   if (start_i) state_d = lmmpc_pkg::S_SUM;
      lmmpc_pkg::S_SUM: begin
        if (sweep_end) begin
          state_d = (n_q <= CW'(2)) ? lmmpc_pkg::S_DONE : lmmpc_pkg::S_DIV;
        end
      end
      lmmpc_pkg::S_DIV: begin
        if (dcnt_q == DCW'(DW-1)) state_d = lmmpc_pkg::S_DIVFIN;
      end
      lmmpc_pkg::S_DIVFIN: state_d = lmmpc_pkg::S_LOOP;
      lmmpc_pkg::S_LOOP: begin
        state_d = (pass_q == PCW'(PCAP)) ? lmmpc_pkg::S_DONE : lmmpc_pkg::S_PASS;
      end
      lmmpc_pkg::S_PASS:   if (sweep_end) state_d = lmmpc_pkg::S_DECIDE;
      lmmpc_pkg::S_DECIDE: begin
        if (eqc || resolved) begin
          state_d = lmmpc_pkg::S_DONE;
        end else if (take_jump) begin
          state_d = shrink_sel ? lmmpc_pkg::S_SHRINK : lmmpc_pkg::S_MULA;
        end else begin
          state_d = lmmpc_pkg::S_LOOP;
        end
      end
      lmmpc_pkg::S_SHRINK: state_d = lmmpc_pkg::S_MULA;
      lmmpc_pkg::S_MULA:   state_d = lmmpc_pkg::S_MULB;
      lmmpc_pkg::S_MULB:   state_d = lmmpc_pkg::S_APPLY;
      lmmpc_pkg::S_APPLY:  state_d = lmmpc_pkg::S_LOOP;
      lmmpc_pkg::S_DONE:   if (ack_i) state_d = lmmpc_pkg::S_IDLE;
      default:             state_d = lmmpc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmmpc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rv_q <= rd_en_o;
    if (rd_en_o) idx_q <= idx_q + CW'(1);
    case (state_q)
      lmmpc_pkg::S_IDLE: begin
        n_q   <= n_i;
        idx_q <= '0;
        sum_q <= '0;
        mn_q  <= {1'b0, {(SW-1){1'b1}}};
        mx_q  <= {1'b1, {(SW-1){1'b0}}};
      end
      lmmpc_pkg::S_SUM: begin
        if (rv_q) begin
          sum_q <= sum_q + SUMW'(s);
          if (s < mn_q) mn_q <= s;
          if (s > mx_q) mx_q <= s;
        end
        if (sweep_end) begin
          med_q  <= (n_q == CW'(1)) ? RW'(sum_q <<< 1) : RW'(sum_q);
          div_q  <= {sum_abs, {FB{1'b0}}};
          rem_q  <= '0;
          dcnt_q <= '0;
          dneg_q <= sum_q[SUMW-1];
        end
      end
      lmmpc_pkg::S_DIV: begin
        rem_q  <= dge ? (rem_t - {1'b0, n_q}) : rem_t;
        div_q  <= {div_q[DW-2:0], dge};
        dcnt_q <= dcnt_q + DCW'(1);
      end
      lmmpc_pkg::S_DIVFIN: begin
        guess_q  <= GW'(qfin);
        pguess_q <= GW'(qfin);
        pinf_q   <= 1'b1;
        js_q     <= cfg_i.step_factor;
        gap_q    <= '0;
        pass_q   <= '0;
      end
      lmmpc_pkg::S_LOOP: begin
        idx_q <= '0;
        lo_q  <= '0;
        hi_q  <= '0;
        bv_q  <= 1'b0;
        av_q  <= 1'b0;
        med_q <= g2;
      end
      lmmpc_pkg::S_PASS: begin
        if (rv_q) begin
          lo_q <= lo_q + CW'(v <= guess_q);
          hi_q <= hi_q + CW'(v >= guess_q);
          if ((v < guess_q) && (!bv_q || (s > nb_q))) begin
            nb_q <= s;
            bv_q <= 1'b1;
          end
          if ((v > guess_q) && (!av_q || (s < na_q))) begin
            na_q <= s;
            av_q <= 1'b1;
          end
        end
      end
      lmmpc_pkg::S_DECIDE: begin
        med_q <= answer;
        if (!(eqc || resolved)) begin
          if (take_jump) begin
            if (shrink_sel) begin
              mag_q  <= pmag;
              base_q <= pguess_q;
              neg_q  <= pimb_q[CW];
            end else begin
              js_q     <= cfg_i.step_factor;
              pimb_q   <= gt ? -$signed({1'b0, d}) : $signed({1'b0, d});
              pinf_q   <= 1'b0;
              gap_q    <= gapw[SW+1] ? '0 : gapw[GPW-1:0];
              pguess_q <= guess_q;
              mag_q    <= d;
              base_q   <= guess_q;
              neg_q    <= gt;
            end
          end else begin
            guess_q <= {nearv, {FB{1'b0}}};
            pass_q  <= pass_q + PCW'(1);
          end
        end
      end
      lmmpc_pkg::S_SHRINK: js_q <= js_prod[2*SCW-1:SCW];
      lmmpc_pkg::S_MULA:   a_q <= mag_q * js_q;
      lmmpc_pkg::S_MULB:   prod_q <= a_q * gap_q;
      lmmpc_pkg::S_APPLY: begin
        guess_q <= clg[GW-1:0];
        pass_q  <= pass_q + PCW'(1);
      end
      default: ;
    endcase
  end

  assign done_o   = state_q == lmmpc_pkg::S_DONE;
  assign median_o = med_q;

endmodule
`default_nettype wire
